### rtl/core/sit_pkg.sv
package sit_pkg;

   // Widths of the request and response fields as seen on the ports.
   localparam int OP_W        = 3;
   localparam int ID_PORT_W   = 16;
   localparam int HANDLE_W    = 16;
   localparam int SLOT_PORT_W = 8;
   localparam int STATUS_W    = 2;

   // Defaults for the top level parameters.
   localparam int SLOTS_DEFAULT   = 16;
   localparam int ID_BITS_DEFAULT = 16;
   localparam int ENTRY_W_DEFAULT = ID_BITS_DEFAULT + HANDLE_W + 1;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
   localparam logic [OP_W-1:0] OP_MARK   = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   // Control program: step addresses.
   localparam int PC_W = 3;
   localparam logic [PC_W-1:0] STEP_FETCH  = 3'd0;
   localparam logic [PC_W-1:0] STEP_MATCH  = 3'd1;
   localparam logic [PC_W-1:0] STEP_ENCODE = 3'd2;
   localparam logic [PC_W-1:0] STEP_READ   = 3'd3;
   localparam logic [PC_W-1:0] STEP_COMMIT = 3'd4;

   // Jump conditions.
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_REQ   = 3'd2;
   localparam logic [COND_W-1:0] COND_MISS     = 3'd3;
   localparam logic [COND_W-1:0] COND_RSP_BUSY = 3'd4;

   typedef struct packed {
      logic              accept;
      logic              vec_load;
      logic              enc_load;
      logic              ram_rd;
      logic              commit;
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
      logic [PC_W-1:0]   next;
   } uword_type;

   // The control program. A step jumps to target when its condition holds,
   // otherwise it moves on to next.
   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '0;
      case (pc)
         STEP_FETCH: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = STEP_FETCH;
            w.next   = STEP_MATCH;
         end
         STEP_MATCH: begin
            w.vec_load = 1'b1;
            w.cond     = COND_NEVER;
            w.target   = STEP_FETCH;
            w.next     = STEP_ENCODE;
         end
         STEP_ENCODE: begin
            w.enc_load = 1'b1;
            w.cond     = COND_MISS;
            w.target   = STEP_COMMIT;
            w.next     = STEP_READ;
         end
         STEP_READ: begin
            w.ram_rd = 1'b1;
            w.cond   = COND_NEVER;
            w.target = STEP_FETCH;
            w.next   = STEP_COMMIT;
         end
         STEP_COMMIT: begin
            w.commit = 1'b1;
            w.cond   = COND_RSP_BUSY;
            w.target = STEP_COMMIT;
            w.next   = STEP_FETCH;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_FETCH;
            w.next   = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

### rtl/core/sit_ram.sv
module sit_ram #(
   parameter int WIDTH = sit_pkg::ENTRY_W_DEFAULT,
   parameter int DEPTH = sit_pkg::SLOTS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/id_slot_table.sv
// The result is registered at the commit step. A request runs through the
// five-step control program (fetch, match, encode, table read, commit) on a
// hit and skips the table read on a miss or an unknown operation; commit waits
// while the previous response is held. Only one request is at work at a time.
// Reset: synchronous; clears every valid bit, the step counter and the
// result valid. Stored ids, handles and marks keep whatever they held.
module id_slot_table #(
   parameter int SLOTS   = sit_pkg::SLOTS_DEFAULT,
   parameter int ID_BITS = sit_pkg::ID_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sit_pkg::OP_W-1:0]         req_operation,
   input  logic [sit_pkg::ID_PORT_W-1:0]    req_client_id,
   input  logic [sit_pkg::HANDLE_W-1:0]     req_handle,
   input  logic [sit_pkg::SLOT_PORT_W-1:0]  req_slot_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sit_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_found,
   output logic [sit_pkg::SLOT_PORT_W-1:0]  rsp_slot,
   output logic [sit_pkg::ID_PORT_W-1:0]    rsp_found_id,
   output logic [sit_pkg::HANDLE_W-1:0]     rsp_found_handle,
   output logic                             rsp_delete_marked
);

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KEY_W   = (ID_BITS < sit_pkg::ID_PORT_W) ? ID_BITS : sit_pkg::ID_PORT_W;
   localparam int ENTRY_W = KEY_W + sit_pkg::HANDLE_W + 1;

   // Control
   logic [sit_pkg::PC_W-1:0] pc_ff, pc_in;
   sit_pkg::uword_type       uw;
   logic                     branch;
   logic                     req_beat;
   logic                     commit_fire;

   // Request held for the whole operation
   logic [sit_pkg::OP_W-1:0]        op_ff;
   logic [KEY_W-1:0]                key_ff;
   logic [sit_pkg::HANDLE_W-1:0]    hnd_ff;
   logic [sit_pkg::SLOT_PORT_W-1:0] idx_ff;

   // Table state kept in flops: valid bits and the ids used for matching
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [KEY_W-1:0] id_ff [SLOTS];

   // Candidate vector, lowest-set-bit encoder and the selected slot
   logic [SLOTS-1:0]  vec_ff, vec_in;
   logic [SLOTS-1:0]  lowest;
   logic [SLOT_W-1:0] enc_addr;
   logic              enc_hit;
   logic [SLOT_W-1:0] addr_ff;
   logic              hit_ff;

   // Entry store
   logic                        ram_we;
   logic [ENTRY_W-1:0]          ram_wdata;
   logic [ENTRY_W-1:0]          ram_rdata;
   logic [KEY_W-1:0]            rd_id;
   logic [sit_pkg::HANDLE_W-1:0] rd_hnd;
   logic                        rd_mark;

   // Response register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sit_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic                             found_ff, found_in;
   logic [sit_pkg::SLOT_PORT_W-1:0]  slot_ff, slot_in;
   logic [sit_pkg::ID_PORT_W-1:0]    found_id_ff, found_id_in;
   logic [sit_pkg::HANDLE_W-1:0]     found_hnd_ff, found_hnd_in;
   logic                             mark_ff, mark_in;

   assign uw        = sit_pkg::ucode_rom(pc_ff);
   assign req_ready = uw.accept;
   assign req_beat  = req_valid && req_ready;

   always_comb begin
      case (uw.cond)
         sit_pkg::COND_NEVER:    branch = 1'b0;
         sit_pkg::COND_ALWAYS:   branch = 1'b1;
         sit_pkg::COND_NO_REQ:   branch = !req_valid;
         sit_pkg::COND_MISS:     branch = !enc_hit;
         sit_pkg::COND_RSP_BUSY: branch = rsp_valid_ff && !rsp_ready;
         default:                branch = 1'b0;
      endcase
      pc_in = branch ? uw.target : uw.next;
   end

   // The commit step only completes once the response register is free.
   assign commit_fire = uw.commit && !(rsp_valid_ff && !rsp_ready);

   // Every slot is tested in parallel against the held request.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         case (op_ff)
            sit_pkg::OP_ADD:    vec_in[i] = !valid_ff[i];
            sit_pkg::OP_REMOVE,
            sit_pkg::OP_LOOKUP,
            sit_pkg::OP_MARK:   vec_in[i] = valid_ff[i] && (id_ff[i] == key_ff);
            sit_pkg::OP_READ:   vec_in[i] = valid_ff[i] &&
                                            (idx_ff == sit_pkg::SLOT_PORT_W'(i));
            default:            vec_in[i] = 1'b0;
         endcase
      end
   end

   // Isolating the lowest set bit leaves a one-hot vector that ORs into an index.
   assign lowest  = vec_ff & (~vec_ff + SLOTS'(1));
   assign enc_hit = |vec_ff;

   always_comb begin
      enc_addr = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (lowest[i]) begin
            enc_addr = enc_addr | SLOT_W'(i);
         end
      end
   end

   assign rd_id   = ram_rdata[ENTRY_W-1 -: KEY_W];
   assign rd_hnd  = ram_rdata[sit_pkg::HANDLE_W:1];
   assign rd_mark = ram_rdata[0];

   assign ram_we    = commit_fire && hit_ff &&
                      ((op_ff == sit_pkg::OP_ADD) || (op_ff == sit_pkg::OP_MARK));
   assign ram_wdata = (op_ff == sit_pkg::OP_ADD) ? {key_ff, hnd_ff, 1'b0}
                                                 : {rd_id, rd_hnd, 1'b1};

   always_comb begin
      valid_in = valid_ff;
      if (commit_fire && hit_ff) begin
         if (op_ff == sit_pkg::OP_ADD) begin
            valid_in[addr_ff] = 1'b1;
         end else if (op_ff == sit_pkg::OP_REMOVE) begin
            valid_in[addr_ff] = 1'b0;
         end
      end
   end

   always_comb begin
      status_in    = sit_pkg::STATUS_OK;
      found_in     = 1'b0;
      slot_in      = '0;
      found_id_in  = '0;
      found_hnd_in = '0;
      mark_in      = 1'b0;
      if (!hit_ff && (op_ff == sit_pkg::OP_ADD)) begin
         status_in = sit_pkg::STATUS_FULL;
      end else if (!hit_ff && (op_ff == sit_pkg::OP_REMOVE)) begin
         status_in = sit_pkg::STATUS_NOT_FOUND;
      end
      if (hit_ff) begin
         slot_in = sit_pkg::SLOT_PORT_W'(addr_ff);
         if (op_ff != sit_pkg::OP_ADD) begin
            found_in     = 1'b1;
            found_id_in  = sit_pkg::ID_PORT_W'(rd_id);
            found_hnd_in = rd_hnd;
            mark_in      = (op_ff == sit_pkg::OP_MARK) ? 1'b1 : rd_mark;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= sit_pkg::STEP_FETCH;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         op_ff  <= req_operation;
         key_ff <= req_client_id[KEY_W-1:0];
         hnd_ff <= req_handle;
         idx_ff <= req_slot_index;
      end
      if (uw.vec_load) begin
         vec_ff <= vec_in;
      end
      if (uw.enc_load) begin
         addr_ff <= enc_addr;
         hit_ff  <= enc_hit;
      end
      if (commit_fire && hit_ff && (op_ff == sit_pkg::OP_ADD)) begin
         id_ff[addr_ff] <= key_ff;
      end
      if (commit_fire) begin
         status_ff    <= status_in;
         found_ff     <= found_in;
         slot_ff      <= slot_in;
         found_id_ff  <= found_id_in;
         found_hnd_ff <= found_hnd_in;
         mark_ff      <= mark_in;
      end
   end

   sit_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (ram_wdata),
      .rd_en   (uw.ram_rd),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_found         = found_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_found_id      = found_id_ff;
   assign rsp_found_handle  = found_hnd_ff;
   assign rsp_delete_marked = mark_ff;

endmodule

### rtl/core/sit_checker.sv
module sit_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [sit_pkg::STATUS_W-1:0]     rsp_status,
   input logic                             rsp_found,
   input logic [sit_pkg::SLOT_PORT_W-1:0]  rsp_slot,
   input logic [sit_pkg::ID_PORT_W-1:0]    rsp_found_id,
   input logic [sit_pkg::HANDLE_W-1:0]     rsp_found_handle,
   input logic                             rsp_delete_marked
);

   // A response beat that is held back must not change under the consumer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_found) && $stable(rsp_slot) &&
          $stable(rsp_found_id) && $stable(rsp_found_handle) &&
          $stable(rsp_delete_marked)))
      else $error("response beat changed while stalled");

   // One request at a time: the table stops taking requests right after a beat.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous one is still at work");

   // A failed add or remove carries no slot contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != sit_pkg::STATUS_OK)) |->
         (!rsp_found && (rsp_slot == '0) && (rsp_found_id == '0) &&
          (rsp_found_handle == '0) && !rsp_delete_marked))
      else $error("error response carries slot contents");

   // Without a hit the contents fields stay zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         ((rsp_found_id == '0) && (rsp_found_handle == '0) && !rsp_delete_marked))
      else $error("contents reported without a hit");

endmodule

bind id_slot_table sit_checker u_sit_checker (.*);
